### sv/bmsa_pkg.sv
// shared types and constants of the binned mean and deviation accumulator
package bmsa_pkg;

  localparam int unsigned BINS    = 4096;
  localparam int unsigned BIN_W   = 12;
  localparam int unsigned SMP_W   = 16;
  localparam int unsigned CNT_W   = 20;
  localparam int unsigned SUM_W   = 36;
  localparam int unsigned SQ_W    = 52;
  localparam int unsigned RES_W   = 24;
  localparam int unsigned ENTRY_W = SUM_W + SQ_W + CNT_W;

  // request codes, code 3 is unused
  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // one bin as stored in memory
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [SQ_W-1:0]  sq;
    logic [CNT_W-1:0] cnt;
  } entry_t;

endpackage

### sv/bmsa_ram.sv
// generic simple dual port ram with registered read
module bmsa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/bmsa_stat.sv
// sequential mean and deviation unit: shared restoring divider, squarer, digit square root
module bmsa_stat import bmsa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] sum_i,
  input  logic [SQ_W-1:0]  sq_i,
  input  logic [CNT_W-1:0] cnt_i,
  output logic             done_o,
  output logic [RES_W-1:0] mean_o,
  output logic [RES_W-1:0] sd_o
);

  localparam int unsigned DVD_W = SQ_W + 16;
  localparam int unsigned MSQ_W = 2 * RES_W;
  localparam int unsigned SREM_W = RES_W + 2;

  typedef enum logic [2:0] {
    S_IDLE, S_DIVM, S_DIVQ, S_MUL, S_DIFF, S_SQRT
  } stat_state_e;

  stat_state_e       state_q;
  logic [6:0]        it_q;
  logic [DVD_W-1:0]  dvd_q;
  logic [CNT_W:0]    rem_q;
  logic [CNT_W-1:0]  div_q;
  logic [SQ_W-1:0]   sq_q;
  logic [RES_W-1:0]  mean_q;
  logic [MSQ_W-1:0]  msq_q;
  logic [MSQ_W-1:0]  m2_q;
  logic [MSQ_W-1:0]  rad_q;
  logic [RES_W-1:0]  root_q;
  logic [SREM_W-1:0] srem_q;
  logic [RES_W-1:0]  sd_q;
  logic              done_q;

  // one restoring division step
  logic [CNT_W:0]   rem_sh;
  logic             div_ge;
  logic [CNT_W:0]   rem_n;
  logic [DVD_W-1:0] dvd_n;

  assign rem_sh = {rem_q[CNT_W-1:0], dvd_q[DVD_W-1]};
  assign div_ge = rem_sh >= {1'b0, div_q};
  assign rem_n  = div_ge ? rem_sh - {1'b0, div_q} : rem_sh;
  assign dvd_n  = {dvd_q[DVD_W-2:0], div_ge};

  // one square root digit step
  logic [SREM_W+1:0] srem_sh;
  logic [SREM_W+1:0] sq_trial;
  logic              sq_ge;
  logic [SREM_W+1:0] srem_n;
  logic [RES_W-1:0]  root_n;

  assign srem_sh  = {srem_q, rad_q[MSQ_W-1 -: 2]};
  assign sq_trial = {2'b00, root_q, 2'b01};
  assign sq_ge    = srem_sh >= sq_trial;
  assign srem_n   = sq_ge ? srem_sh - sq_trial : srem_sh;
  assign root_n   = {root_q[RES_W-2:0], sq_ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      it_q    <= '0;
      done_q  <= 1'b0;
      dvd_q   <= '0;
      rem_q   <= '0;
      div_q   <= '0;
      sq_q    <= '0;
      mean_q  <= '0;
      msq_q   <= '0;
      m2_q    <= '0;
      rad_q   <= '0;
      root_q  <= '0;
      srem_q  <= '0;
      sd_q    <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            dvd_q   <= DVD_W'({sum_i, 8'b0});
            rem_q   <= '0;
            div_q   <= cnt_i;
            sq_q    <= sq_i;
            it_q    <= '0;
            state_q <= S_DIVM;
          end
        end
        // sum * 256 / count
        S_DIVM: begin
          if (it_q == 7'(DVD_W - 1)) begin
            mean_q  <= dvd_n[RES_W-1:0];
            dvd_q   <= {sq_q, 16'b0};
            rem_q   <= '0;
            it_q    <= '0;
            state_q <= S_DIVQ;
          end else begin
            dvd_q <= dvd_n;
            rem_q <= rem_n;
            it_q  <= it_q + 7'd1;
          end
        end
        // sumsq * 65536 / count
        S_DIVQ: begin
          if (it_q == 7'(DVD_W - 1)) begin
            msq_q   <= dvd_n[MSQ_W-1:0];
            state_q <= S_MUL;
          end else begin
            dvd_q <= dvd_n;
            rem_q <= rem_n;
            it_q  <= it_q + 7'd1;
          end
        end
        S_MUL: begin
          m2_q    <= mean_q * mean_q;
          state_q <= S_DIFF;
        end
        // clamp negative variance to zero
        S_DIFF: begin
          rad_q   <= (msq_q > m2_q) ? msq_q - m2_q : '0;
          root_q  <= '0;
          srem_q  <= '0;
          it_q    <= '0;
          state_q <= S_SQRT;
        end
        S_SQRT: begin
          root_q <= root_n;
          srem_q <= srem_n[SREM_W-1:0];
          rad_q  <= {rad_q[MSQ_W-3:0], 2'b00};
          if (it_q == 7'(RES_W - 1)) begin
            sd_q    <= root_n;
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            it_q <= it_q + 7'd1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign mean_o = mean_q;
  assign sd_o   = sd_q;

endmodule

### sv/binned_mean_stddev_accumulator_unit.sv
// binned mean and standard deviation accumulator, top level
// add: ram read at accept, then read-modify-write; no new beat is taken until the write is done
// read: a non-empty bin goes through the bit-serial divider twice, the squarer and the bit-serial root
// clear: sweeps the ram one bin per cycle, with input stalled
// reset: the same clearing sweep runs before the first beat is taken
// result sits in an output register, so adds proceed while a read result waits
module binned_mean_stddev_accumulator_unit import bmsa_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              req_type_i,
  input  logic signed [12:0]      bin_index_i,
  input  logic signed [16:0]      sample_value_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [BIN_W-1:0]        out_bin_o,
  output logic [RES_W-1:0]        mean_q8_o,
  output logic [RES_W-1:0]        stddev_q8_o,
  output logic [CNT_W-1:0]        sample_count_o,
  output logic                    bin_empty_o
);

  typedef enum logic [2:0] {
    ST_CLR, ST_IDLE, ST_ADD, ST_RD, ST_CALC, ST_PUSH
  } state_e;

  state_e            state_q;
  logic [BIN_W-1:0]  clr_addr_q;
  logic [BIN_W-1:0]  bin_q;
  logic              in_range_q;
  logic [SMP_W-1:0]  smp_q;
  logic [2*SMP_W-1:0] smp_sq_q;
  logic [RES_W-1:0]  pend_mean_q;
  logic [RES_W-1:0]  pend_sd_q;
  logic [CNT_W-1:0]  pend_cnt_q;
  logic              out_valid_q;
  logic [BIN_W-1:0]  out_bin_q;
  logic [RES_W-1:0]  mean_q;
  logic [RES_W-1:0]  sd_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              empty_q;

  logic              in_beat;
  logic              in_range;
  logic              ram_we;
  logic [BIN_W-1:0]  ram_waddr;
  entry_t            ram_wdata;
  entry_t            rd_entry;
  logic [ENTRY_W-1:0] ram_rdata;
  logic              stat_start;
  logic              stat_done;
  logic [RES_W-1:0]  stat_mean;
  logic [RES_W-1:0]  stat_sd;

  assign in_ready_o = state_q == ST_IDLE;
  assign in_beat    = in_valid_i && in_ready_o;
  assign in_range   = !bin_index_i[12];
  assign rd_entry   = entry_t'(ram_rdata);

  // write port: clearing sweep or accumulate
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = bin_q;
    ram_wdata = '0;
    if (state_q == ST_CLR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
    end else if (state_q == ST_ADD && rd_entry.cnt != '1) begin
      ram_we        = 1'b1;
      ram_wdata.sum = rd_entry.sum + SUM_W'(smp_q);
      ram_wdata.sq  = rd_entry.sq + SQ_W'(smp_sq_q);
      ram_wdata.cnt = rd_entry.cnt + CNT_W'(1);
    end
  end

  bmsa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (BINS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (bin_index_i[BIN_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign stat_start = state_q == ST_RD && in_range_q && rd_entry.cnt != '0;

  bmsa_stat u_stat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (stat_start),
    .sum_i   (rd_entry.sum),
    .sq_i    (rd_entry.sq),
    .cnt_i   (rd_entry.cnt),
    .done_o  (stat_done),
    .mean_o  (stat_mean),
    .sd_o    (stat_sd)
  );

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_addr_q  <= '0;
      bin_q       <= '0;
      in_range_q  <= 1'b0;
      smp_q       <= '0;
      smp_sq_q    <= '0;
      pend_mean_q <= '0;
      pend_sd_q   <= '0;
      pend_cnt_q  <= '0;
      out_valid_q <= 1'b0;
      out_bin_q   <= '0;
      mean_q      <= '0;
      sd_q        <= '0;
      cnt_q       <= '0;
      empty_q     <= 1'b0;
    end else begin
      // the push state reloads the output register itself
      if (out_valid_q && out_ready_i && state_q != ST_PUSH) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLR: begin
          clr_addr_q <= clr_addr_q + BIN_W'(1);
          if (clr_addr_q == BIN_W'(BINS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_beat) begin
            bin_q      <= bin_index_i[BIN_W-1:0];
            in_range_q <= in_range;
            smp_q      <= sample_value_i[SMP_W-1:0];
            smp_sq_q   <= sample_value_i[SMP_W-1:0] * sample_value_i[SMP_W-1:0];
            case (req_type_i)
              REQ_ADD: begin
                if (in_range && !sample_value_i[16]) begin
                  state_q <= ST_ADD;
                end
              end
              REQ_READ: state_q <= ST_RD;
              REQ_CLEAR: begin
                clr_addr_q <= '0;
                state_q    <= ST_CLR;
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_ADD: state_q <= ST_IDLE;
        ST_RD: begin
          pend_cnt_q  <= in_range_q ? rd_entry.cnt : '0;
          pend_mean_q <= '0;
          pend_sd_q   <= '0;
          state_q     <= stat_start ? ST_CALC : ST_PUSH;
        end
        ST_CALC: begin
          if (stat_done) begin
            pend_mean_q <= stat_mean;
            pend_sd_q   <= stat_sd;
            state_q     <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_bin_q   <= bin_q;
            mean_q      <= pend_mean_q;
            sd_q        <= pend_sd_q;
            cnt_q       <= pend_cnt_q;
            empty_q     <= pend_cnt_q == '0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_bin_o      = out_bin_q;
  assign mean_q8_o      = mean_q;
  assign stddev_q8_o    = sd_q;
  assign sample_count_o = cnt_q;
  assign bin_empty_o    = empty_q;

  // no beat is taken while the memory is being cleared
  a_clr_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLR |-> !in_ready_o) else $error("input taken during clear");

  // memory is written only by the sweep or an accumulate
  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_CLR || state_q == ST_ADD)) else $error("stray ram write");

  // the math unit finishes only while a read waits on it
  a_done_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_done |-> state_q == ST_CALC) else $error("unexpected stat done");

  // a reported empty bin carries zero statistics
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && empty_q) |-> (mean_q == '0 && sd_q == '0 && cnt_q == '0))
    else $error("empty bin with nonzero stats");

endmodule

### tb/tb_binned_mean_stddev_accumulator_unit.sv
// testbench for the binned mean and deviation accumulator: directed table, then random beats
module tb_binned_mean_stddev_accumulator_unit;
  import bmsa_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned CNT_MAX = (1 << CNT_W) - 1;
  localparam int unsigned SMP_MAX = (1 << SMP_W) - 1;
  localparam int RAND_BEATS = 1150;

  typedef struct packed {
    logic [BIN_W-1:0] bin;
    logic [RES_W-1:0] mean;
    logic [RES_W-1:0] sd;
    logic [CNT_W-1:0] cnt;
    logic             empty;
  } stats_t;

  typedef struct {
    logic [1:0] rq;
    int         bn;
    int         sv;
    bit         typed;
    stats_t     res;
  } dir_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [1:0]        req_type_i;
  logic signed [12:0] bin_index_i;
  logic signed [16:0] sample_value_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [BIN_W-1:0]  out_bin_o;
  logic [RES_W-1:0]  mean_q8_o;
  logic [RES_W-1:0]  stddev_q8_o;
  logic [CNT_W-1:0]  sample_count_o;
  logic              bin_empty_o;

  // predicted bin contents
  longint unsigned acc_sum [BINS];
  longint unsigned acc_sq  [BINS];
  int unsigned     acc_cnt [BINS];

  stats_t stats_q[$];
  int     err_cnt;
  int     src_idle_pct;
  int     snk_stall_pct;
  int     hold_left;

  binned_mean_stddev_accumulator_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .bin_index_i    (bin_index_i),
    .sample_value_i (sample_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_bin_o      (out_bin_o),
    .mean_q8_o      (mean_q8_o),
    .stddev_q8_o    (stddev_q8_o),
    .sample_count_o (sample_count_o),
    .bin_empty_o    (bin_empty_o)
  );

  // directed rows, expected statistics typed in where they are obvious
  dir_row_t dir_tab [23] = '{
    '{REQ_READ,      0,      0, 1'b1, '{12'd0,    24'd0,        24'd0, 20'd0, 1'b1}},
    '{REQ_READ,     -1,      0, 1'b1, '{12'hfff,  24'd0,        24'd0, 20'd0, 1'b1}},
    '{REQ_READ,  -4096,      0, 1'b1, '{12'd0,    24'd0,        24'd0, 20'd0, 1'b1}},
    '{REQ_ADD,       0,  65535, 1'b0, '0},
    '{REQ_ADD,       0,  65535, 1'b0, '0},
    '{REQ_READ,      0,      0, 1'b1, '{12'd0,    24'd16776960, 24'd0, 20'd2, 1'b0}},
    '{REQ_ADD,    4095,      0, 1'b0, '0},
    '{REQ_READ,   4095,  65535, 1'b1, '{12'd4095, 24'd0,        24'd0, 20'd1, 1'b0}},
    '{REQ_ADD,       5,     -1, 1'b0, '0},
    '{REQ_ADD,       5, -65536, 1'b0, '0},
    '{REQ_ADD,      -1,    100, 1'b0, '0},
    '{REQ_READ,      5,      0, 1'b1, '{12'd5,    24'd0,        24'd0, 20'd0, 1'b1}},
    '{REQ_ADD,       7,      1, 1'b0, '0},
    '{REQ_ADD,       7,      2, 1'b0, '0},
    '{REQ_ADD,       7,      4, 1'b0, '0},
    '{REQ_UNUSED,    7,      9, 1'b0, '0},
    '{REQ_READ,      7,      0, 1'b0, '0},
    '{REQ_CLEAR,  4095,  -4096, 1'b0, '0},
    '{REQ_READ,      0,      0, 1'b1, '{12'd0,    24'd0,        24'd0, 20'd0, 1'b1}},
    '{REQ_READ,   4095,      0, 1'b1, '{12'd4095, 24'd0,        24'd0, 20'd0, 1'b1}},
    '{REQ_ADD,       1,      3, 1'b0, '0},
    '{REQ_ADD,       1,      3, 1'b0, '0},
    '{REQ_READ,      1,      0, 1'b1, '{12'd1,    24'd768,      24'd0, 20'd2, 1'b0}}
  };

  // floor square root, one result bit per pass
  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // update the bin image for one beat, return 1 when a read result is due
  function automatic bit bin_update(logic [1:0] rq, int bn, int sv, output stats_t r);
    bit              in_range;
    longint unsigned s, cnt, mean, msq, m2, sd;
    in_range = (bn >= 0) && (bn < BINS);
    r = '0;
    case (rq)
      REQ_ADD: begin
        if (in_range && sv >= 0 && acc_cnt[bn] < CNT_MAX) begin
          s = (sv > SMP_MAX) ? SMP_MAX : sv;
          acc_sum[bn] += s;
          acc_sq[bn]  += s * s;
          acc_cnt[bn] += 1;
        end
        return 1'b0;
      end
      REQ_READ: begin
        cnt = 0; mean = 0; sd = 0;
        if (in_range) begin
          cnt = acc_cnt[bn];
          if (cnt != 0) begin
            mean = (acc_sum[bn] * 256) / cnt;
            msq  = (acc_sq[bn] / cnt) * 65536 + ((acc_sq[bn] % cnt) * 65536) / cnt;
            m2   = mean * mean;
            if (msq > m2) sd = floor_sqrt(msq - m2);
            if (mean > 24'hffffff) mean = 24'hffffff;
            if (sd > 24'hffffff) sd = 24'hffffff;
          end
        end
        r.bin   = bn[BIN_W-1:0];
        r.mean  = mean[RES_W-1:0];
        r.sd    = sd[RES_W-1:0];
        r.cnt   = (cnt > CNT_MAX) ? CNT_MAX : cnt[CNT_W-1:0];
        r.empty = (cnt == 0);
        return 1'b1;
      end
      REQ_CLEAR: begin
        for (int i = 0; i < BINS; i++) begin
          acc_sum[i] = 0; acc_sq[i] = 0; acc_cnt[i] = 0;
        end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  // offer one beat after a random gap, wait for it to be taken
  task automatic send_beat(logic [1:0] rq, int bn, int sv, bit typed, stats_t tv);
    stats_t pr;
    bit     due;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= rq;
    bin_index_i    <= bn[12:0];
    sample_value_i <= sv[16:0];
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    due = bin_update(rq, bn, sv, pr);
    if (due) stats_q.push_back(typed ? tv : pr);
  endtask

  task automatic send_random();
    int r, bn, sv, k;
    r = $urandom_range(99);
    k = $urandom_range(99);
    if (k < 88) bn = $urandom_range(15);
    else if (k < 94) bn = $urandom_range(4095);
    else bn = -$urandom_range(4096, 1);
    k = $urandom_range(99);
    if (k < 30) sv = $urandom_range(255);
    else if (k < 80) sv = $urandom_range(65535);
    else if (k < 90) sv = 65535 - $urandom_range(3);
    else sv = -$urandom_range(65536, 1);
    if (r < 78) send_beat(REQ_ADD, bn, sv, 1'b0, '0);
    else if (r < 95) send_beat(REQ_READ, bn, sv, 1'b0, '0);
    else if (r < 96) send_beat(REQ_CLEAR, bn, sv, 1'b0, '0);
    else send_beat(REQ_UNUSED, bn, sv, 1'b0, '0);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (stats_q.size() != 0) @(posedge clk_i);
  endtask

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // result side: check accepted beats, then pick the next ready
  initial begin
    stats_t e;
    out_ready_i = 1'b0;
    hold_left = 0;
    err_cnt = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (stats_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("unexpected result beat, bin %0d", out_bin_o);
        end else begin
          e = stats_q.pop_front();
          if (e.bin !== out_bin_o || e.mean !== mean_q8_o || e.sd !== stddev_q8_o ||
              e.cnt !== sample_count_o || e.empty !== bin_empty_o) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("bad result: exp bin %0d mean %0d sd %0d cnt %0d empty %0d, got %0d %0d %0d %0d %0d",
                       e.bin, e.mean, e.sd, e.cnt, e.empty, out_bin_o, mean_q8_o,
                       stddev_q8_o, sample_count_o, bin_empty_o);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // run limit
  initial begin
    #(20 * 1500000);
    $display("binned_mean_stddev_accumulator_unit: mismatch");
    $finish;
  end

  // stimulus
  initial begin
    int guard;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    req_type_i     = REQ_ADD;
    bin_index_i    = '0;
    sample_value_i = '0;
    src_idle_pct   = 0;
    snk_stall_pct  = 0;
    for (int i = 0; i < BINS; i++) begin
      acc_sum[i] = 0; acc_sq[i] = 0; acc_cnt[i] = 0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i])
      send_beat(dir_tab[i].rq, dir_tab[i].bn, dir_tab[i].sv, dir_tab[i].typed, dir_tab[i].res);

    // phase: no idling
    for (int i = 0; i < RAND_BEATS / 4; i++) send_random();
    // sender pauses until every result is back
    wait_drained();

    // phase: receiver stalls, with one long hold-off while reads pile up
    snk_stall_pct = 69;
    hold_left = 400;
    for (int i = 0; i < 6; i++) begin
      send_beat(REQ_ADD, i, $urandom_range(65535), 1'b0, '0);
      send_beat(REQ_READ, i, 0, 1'b0, '0);
    end
    for (int i = 0; i < RAND_BEATS / 4; i++) send_random();

    // phase: sender idles
    snk_stall_pct = 0;
    src_idle_pct  = 69;
    for (int i = 0; i < RAND_BEATS / 4; i++) send_random();

    // phase: both idle
    snk_stall_pct = 26;
    src_idle_pct  = 26;
    for (int i = 0; i < RAND_BEATS / 4; i++) send_random();

    in_valid_i <= 1'b0;
    guard = 0;
    while (stats_q.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (300) @(posedge clk_i);
    if (err_cnt == 0 && stats_q.size() == 0) begin
      $display("binned_mean_stddev_accumulator_unit: match");
    end else begin
      $display("binned_mean_stddev_accumulator_unit: mismatch");
    end
    $finish;
  end

endmodule
